[src/ttpe_pkg.sv]
// Shared constants and types for the travel-time position estimator.
// No dependencies; imported by ttpe_div and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ttpe_pkg;

   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int TRAVEL_W              = 20;
   localparam int ELAPSED_W             = 16;
   localparam int STORED_W              = 8;
   localparam int MODE_W                = 3;
   localparam int PCT_W                 = 7;
   localparam int MOTION_W              = 2;
   localparam int CSR_IDX_W             = 1;
   // elapsed_ms * 100 needs 23 bits
   localparam int SCALED_W              = 23;
   localparam int PCT_FULL              = 100;
   localparam int TRAVEL_RESET          = 30000;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK       = 3'd0,
      MODE_START_OPEN = 3'd1,
      MODE_START_CLOSE = 3'd2,
      MODE_STOP       = 3'd3,
      MODE_SET_OPEN   = 3'd4,
      MODE_SET_CLOSED = 3'd5,
      MODE_RESTORE    = 3'd6,
      MODE_UNUSED     = 3'd7
   } mode_type;

   typedef enum logic [MOTION_W-1:0] {
      MOTION_IDLE    = 2'd0,
      MOTION_OPENING = 2'd1,
      MOTION_CLOSING = 2'd2
   } motion_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OPEN_TRAVEL  = 1'd0,
      CSR_CLOSE_TRAVEL = 1'd1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_APPLY  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

endpackage : ttpe_pkg

`default_nettype wire

[src/ttpe_div.sv]
// Restoring divider, one quotient bit per cycle, for the travel delta.
// Depends on ttpe_pkg for the divisor width.
`timescale 1ns / 1ps
`default_nettype none

module ttpe_div
   import ttpe_pkg::*;
#(
   parameter int NUM_W = SCALED_W + FRACTION_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_W-1:0]    numerator,
   input  wire logic [TRAVEL_W-1:0] divisor,
   output logic                     done,
   output logic [NUM_W-1:0]         quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [TRAVEL_W-1:0] rem_ff, rem_in;
   logic [TRAVEL_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [TRAVEL_W:0]   trial;
   logic [TRAVEL_W:0]   diff;
   logic                fits;

   // shift in the next numerator bit and try the subtraction
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[TRAVEL_W-1:0] : trial[TRAVEL_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : ttpe_div

`default_nettype wire

[src/travel_time_position_estimator_core.sv]
// Top level of the travel-time position estimator: sequencer, state and ports.
// Depends on ttpe_pkg and ttpe_div.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | mode, elapsed_ms, stored_percent, stored_valid
//   rsp_    | out       | rsp_valid/rsp_ready  | position_percent, motion, position_known,
//           |           |                      | save_request
//   csr_    | in        | csr_we               | csr_index, csr_wdata
//
// A moving tick, start or stop with nonzero elapsed time runs through the bit-serial divider
// in ST_DIVIDE and then through ST_APPLY before the result shows in ST_RESULT.
// Any other item goes from ST_IDLE to ST_APPLY and then to ST_RESULT.
// The block takes one item at a time; req_ready is low until the result is taken.
// Reset is synchronous and returns position 0, idle, unknown, and 30000 ms travel times.
`timescale 1ns / 1ps
`default_nettype none

module travel_time_position_estimator_core
   import ttpe_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [ELAPSED_W-1:0] req_elapsed_ms,
   input  wire logic [STORED_W-1:0]  req_stored_percent,
   input  wire logic                 req_stored_valid,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [PCT_W-1:0]          rsp_position_percent,
   output logic [MOTION_W-1:0]       rsp_motion,
   output logic                      rsp_position_known,
   output logic                      rsp_save_request,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TRAVEL_W-1:0]  csr_wdata
);

   localparam int POS_W = PCT_W + FRACTION_BITS;
   localparam int NUM_W = SCALED_W + FRACTION_BITS;
   localparam logic [POS_W-1:0] FULL_SCALE = POS_W'(PCT_FULL) << FRACTION_BITS;
   localparam logic [POS_W-1:0] HALF_LSB   = POS_W'(1) << (FRACTION_BITS - 1);

   state_type           state_ff, state_in;
   logic [TRAVEL_W-1:0] open_travel_ff, open_travel_in;
   logic [TRAVEL_W-1:0] close_travel_ff, close_travel_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   motion_type          motion_ff, motion_in;
   logic                known_ff, known_in;
   logic                save_ff, save_in;

   // latched item
   mode_type            mode_ff, mode_in;
   logic [STORED_W-1:0] stored_ff, stored_in;
   logic                stored_ok_ff, stored_ok_in;
   logic                move_ff, move_in;

   logic                accept;
   logic                need_move;
   logic [SCALED_W-1:0] scaled;
   logic [NUM_W-1:0]    numerator;
   logic [TRAVEL_W-1:0] travel_sel;
   logic [TRAVEL_W-1:0] divisor;
   logic                div_done;
   logic [NUM_W-1:0]    quotient;
   logic [POS_W-1:0]    delta;
   logic [POS_W:0]      open_sum;
   logic                hit_open;
   logic                hit_closed;
   logic [POS_W-1:0]    rounded;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // movement applies only while moving, with time gone by, in tick/start/stop modes
   assign need_move = (motion_ff != MOTION_IDLE) && (req_elapsed_ms != '0) &&
                      (req_mode <= MODE_STOP);

   assign scaled     = SCALED_W'(req_elapsed_ms) * SCALED_W'(PCT_FULL);
   assign numerator  = {scaled, {FRACTION_BITS{1'b0}}};
   assign travel_sel = (motion_ff == MOTION_OPENING) ? open_travel_ff : close_travel_ff;
   assign divisor    = (travel_sel == '0) ? TRAVEL_W'(1) : travel_sel;

   ttpe_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && need_move),
      .numerator(numerator),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // anything at or above full scale hits the end stop either way
   assign delta      = (quotient >= NUM_W'(FULL_SCALE)) ? FULL_SCALE : quotient[POS_W-1:0];
   assign open_sum   = {1'b0, pos_ff} + {1'b0, delta};
   assign hit_open   = (open_sum >= {1'b0, FULL_SCALE});
   assign hit_closed = (delta >= pos_ff);

   always_comb begin
      state_in        = state_ff;
      open_travel_in  = open_travel_ff;
      close_travel_in = close_travel_ff;
      pos_in          = pos_ff;
      motion_in       = motion_ff;
      known_in        = known_ff;
      save_in         = save_ff;
      mode_in         = mode_ff;
      stored_in       = stored_ff;
      stored_ok_in    = stored_ok_ff;
      move_in         = move_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_OPEN_TRAVEL:  open_travel_in  = csr_wdata;
            CSR_CLOSE_TRAVEL: close_travel_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in      = mode_type'(req_mode);
               stored_in    = req_stored_percent;
               stored_ok_in = req_stored_valid;
               move_in      = need_move;
               state_in     = need_move ? ST_DIVIDE : ST_APPLY;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            save_in = 1'b0;
            // pending movement first, with end-stop clamp
            if (move_ff) begin
               if (motion_ff == MOTION_OPENING) begin
                  if (hit_open) begin
                     pos_in    = FULL_SCALE;
                     motion_in = MOTION_IDLE;
                     known_in  = 1'b1;
                     save_in   = 1'b1;
                  end else begin
                     pos_in = open_sum[POS_W-1:0];
                  end
               end else begin
                  if (hit_closed) begin
                     pos_in    = '0;
                     motion_in = MOTION_IDLE;
                     known_in  = 1'b1;
                     save_in   = 1'b1;
                  end else begin
                     pos_in = pos_ff - delta;
                  end
               end
            end
            case (mode_ff)
               MODE_TICK: ;
               MODE_START_OPEN:  motion_in = MOTION_OPENING;
               MODE_START_CLOSE: motion_in = MOTION_CLOSING;
               MODE_STOP: begin
                  motion_in = MOTION_IDLE;
                  known_in  = 1'b1;
                  save_in   = 1'b1;
               end
               MODE_SET_OPEN: begin
                  pos_in    = FULL_SCALE;
                  motion_in = MOTION_IDLE;
                  known_in  = 1'b1;
                  save_in   = 1'b1;
               end
               MODE_SET_CLOSED: begin
                  pos_in    = '0;
                  motion_in = MOTION_IDLE;
                  known_in  = 1'b1;
                  save_in   = 1'b1;
               end
               MODE_RESTORE: begin
                  if (stored_ok_ff && (stored_ff <= STORED_W'(PCT_FULL))) begin
                     pos_in   = {stored_ff[PCT_W-1:0], {FRACTION_BITS{1'b0}}};
                     known_in = 1'b1;
                  end
               end
               default: ;
            endcase
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         open_travel_ff  <= TRAVEL_W'(TRAVEL_RESET);
         close_travel_ff <= TRAVEL_W'(TRAVEL_RESET);
         pos_ff          <= '0;
         motion_ff       <= MOTION_IDLE;
         known_ff        <= 1'b0;
         save_ff         <= 1'b0;
      end else begin
         state_ff        <= state_in;
         open_travel_ff  <= open_travel_in;
         close_travel_ff <= close_travel_in;
         pos_ff          <= pos_in;
         motion_ff       <= motion_in;
         known_ff        <= known_in;
         save_ff         <= save_in;
      end
      mode_ff      <= mode_in;
      stored_ff    <= stored_in;
      stored_ok_ff <= stored_ok_in;
      move_ff      <= move_in;
   end

   // round half up to whole percent; state holds while the result waits
   assign rounded              = pos_ff + HALF_LSB;
   assign rsp_valid            = (state_ff == ST_RESULT);
   assign rsp_position_percent = rounded[POS_W-1:FRACTION_BITS];
   assign rsp_motion           = motion_ff;
   assign rsp_position_known   = known_ff;
   assign rsp_save_request     = save_ff;

endmodule : travel_time_position_estimator_core

`default_nettype wire
